// ----- rtl/ksp_pkg.sv -----
// Shared types, constants and helper functions for the k-mer seed prefilter.
// Used by every module of the block except ksp_ram; depends on nothing else.
`default_nettype none

package ksp_pkg;

  // Seed table geometry
  localparam int unsigned SEED_CAPACITY = 262144;
  localparam int unsigned ADDR_W = (SEED_CAPACITY > 1) ? $clog2(SEED_CAPACITY) : 1;
  localparam int unsigned CNT_W  = $clog2(SEED_CAPACITY + 1);

  // Field widths
  localparam int unsigned SEED_W     = 64;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned K_W        = 6;
  localparam int unsigned HITS_W     = 8;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned OUT_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 8;

  // Window length limits and run saturation
  localparam logic [K_W-1:0] K_MIN   = 6'd12;
  localparam logic [K_W-1:0] K_MAX   = 6'd32;
  localparam logic [K_W-1:0] RUN_MAX = 6'd63;

  // Register reset values
  localparam logic [K_W-1:0]    KMER_RESET     = 6'd16;
  localparam logic [HITS_W-1:0] HIT_GOAL_RESET = 8'd1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KMER_LENGTH = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIT_GOAL    = 8'd1;

  // Opcodes
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OP_W-1:0] OP_CHAR   = 2'd2;

  // Table status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DUP   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ORDER = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

  // Result kinds
  localparam logic KIND_TABLE   = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // capture the accepted word
    logic exec;    // apply the opcode
    logic probe;   // issue a seed memory read at mid
    logic narrow;  // compare read data and shrink the range
    logic emit;    // load the output register
  } ksp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic exec_search;  // this character completes a window worth looking up
    logic exec_result;  // this word produces a result
    logic range_open;   // lo < hi
    logic key_eq;       // probed seed equals the window
    logic want_result;  // held word is the last of its read
    logic out_free;     // output register can take a word
  } ksp_stat_t;

  typedef struct packed {
    logic       ok;
    logic [1:0] code;
  } base_t;

  // A/C/G/T in either case to 2-bit code
  function automatic base_t decode_base(input logic [CHAR_W-1:0] ch);
    base_t b;
    b = '0;
    unique case (ch)
      8'h41, 8'h61: b = '{ok: 1'b1, code: 2'd0};  // A a
      8'h43, 8'h63: b = '{ok: 1'b1, code: 2'd1};  // C c
      8'h47, 8'h67: b = '{ok: 1'b1, code: 2'd2};  // G g
      8'h54, 8'h74: b = '{ok: 1'b1, code: 2'd3};  // T t
      default:      b = '{ok: 1'b0, code: 2'd0};
    endcase
    return b;
  endfunction

  // k saturated into K_MIN..K_MAX
  function automatic logic [K_W-1:0] clamp_k(input logic [K_W-1:0] k);
    if (k < K_MIN) return K_MIN;
    if (k > K_MAX) return K_MAX;
    return k;
  endfunction

  // Low 2k bits set; shift by 64 gives all ones
  function automatic logic [SEED_W-1:0] window_mask(input logic [K_W-1:0] k);
    logic [K_W:0] sh;
    sh = {k, 1'b0};
    return ~({SEED_W{1'b1}} << sh);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/ksp_ram.sv -----
// Generic single-clock RAM: one write port, one read port with registered data.
// Holds the seed table; no dependencies.
`default_nettype none

module ksp_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  wire                                         clk,
  input  wire                                         wr_en,
  input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire  [WIDTH-1:0]                            wr_data,
  input  wire                                         rd_en,
  input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                            rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ksp_ctrl.sv -----
// Sequencing state machine of the k-mer seed prefilter.
// Depends on ksp_pkg for the command and status structs.
`default_nettype none

module ksp_ctrl (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire ksp_pkg::ksp_stat_t  stat,
  output ksp_pkg::ksp_cmd_t        cmd
);
  import ksp_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EXEC   = 5'b00010,
    S_SEARCH = 5'b00100,
    S_CHECK  = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        priority if (stat.exec_search) begin
          state_nxt = S_SEARCH;
        end else if (stat.exec_result) begin
          state_nxt = S_FINISH;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SEARCH: begin
        if (stat.range_open) begin
          cmd.probe = 1'b1;
          state_nxt = S_CHECK;
        end else begin
          state_nxt = stat.want_result ? S_FINISH : S_IDLE;
        end
      end
      S_CHECK: begin
        cmd.narrow = 1'b1;
        if (stat.key_eq) begin
          state_nxt = stat.want_result ? S_FINISH : S_IDLE;
        end else begin
          state_nxt = S_SEARCH;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ksp_dp.sv -----
// Datapath of the k-mer seed prefilter: item capture, config registers,
// rolling window, seed table, binary search range and output register.
// Depends on ksp_pkg and ksp_ram.
`default_nettype none

module ksp_dp (
  input  wire                                  clk,
  input  wire                                  rst_n,
  // captured input word
  input  wire  [ksp_pkg::OP_W-1:0]             in_op,
  input  wire  [ksp_pkg::SEED_W-1:0]           in_seed,
  input  wire  [ksp_pkg::CHAR_W-1:0]           in_char,
  input  wire                                  in_last,
  // configuration writes
  input  wire                                  cfg_we,
  input  wire  [ksp_pkg::CFG_IDX_W-1:0]        cfg_idx,
  input  wire  [ksp_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  // controller link
  input  wire ksp_pkg::ksp_cmd_t               cmd,
  output ksp_pkg::ksp_stat_t                   stat,
  // result word
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic                                 out_kind,
  output logic [ksp_pkg::STATUS_W-1:0]         out_status,
  output logic [ksp_pkg::HITS_W-1:0]           out_hits,
  output logic                                 out_passed
);
  import ksp_pkg::*;

  // Held word
  logic [OP_W-1:0]   op_r;
  logic [SEED_W-1:0] seed_r;
  logic [CHAR_W-1:0] char_r;
  logic              last_r;

  // Config
  logic [K_W-1:0]    kmer_length_r, kmer_length_nxt;
  logic [HITS_W-1:0] hit_goal_r, hit_goal_nxt;

  // Table and read state
  logic [CNT_W-1:0]    seed_count_r, seed_count_nxt;
  logic [SEED_W-1:0]   last_seed_r, last_seed_nxt;
  logic [SEED_W-1:0]   rolling_r, rolling_nxt;
  logic [K_W-1:0]      run_r, run_nxt;
  logic [HITS_W-1:0]   hits_r, hits_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;

  // Search range
  logic [CNT_W-1:0] lo_r, lo_nxt, hi_r, hi_nxt, mid;

  // Output register
  logic                out_valid_r, out_valid_nxt;
  logic                out_kind_r, out_kind_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [HITS_W-1:0]   out_hits_r, out_hits_nxt;
  logic                out_passed_r, out_passed_nxt;

  // Combinational helpers
  logic [K_W-1:0]      k_eff, run_inc;
  logic [HITS_W-1:0]   mh, verdict_hits;
  base_t               bd;
  logic [SEED_W-1:0]   roll_shift, rd_data;
  logic [STATUS_W-1:0] app_status;
  logic                mem_we;

  assign k_eff      = clamp_k(kmer_length_r);
  assign mh         = (hit_goal_r == '0) ? HITS_W'(1) : hit_goal_r;
  assign bd         = decode_base(char_r);
  assign roll_shift = ((rolling_r << 2) | SEED_W'(bd.code)) & window_mask(k_eff);
  assign run_inc    = (run_r == RUN_MAX) ? run_r : run_r + 1'b1;
  assign mid        = lo_r + ((hi_r - lo_r) >> 1);
  assign verdict_hits = (hits_r < mh) ? hits_r : mh;

  // Append ordering check against the last stored seed
  always_comb begin
    priority if (seed_count_r != '0 && seed_r == last_seed_r) begin
      app_status = ST_DUP;
    end else if (seed_count_r != '0 && seed_r < last_seed_r) begin
      app_status = ST_ORDER;
    end else if (seed_count_r >= CNT_W'(SEED_CAPACITY)) begin
      app_status = ST_FULL;
    end else begin
      app_status = ST_OK;
    end
  end

  assign mem_we = cmd.exec && (op_r == OP_APPEND) && (app_status == ST_OK);

  // Seed table
  ksp_ram #(
    .WIDTH (SEED_W),
    .DEPTH (SEED_CAPACITY)
  ) u_table (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (seed_count_r[ADDR_W-1:0]),
    .wr_data (seed_r),
    .rd_en   (cmd.probe),
    .rd_addr (mid[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  // Status to controller
  always_comb begin
    stat.exec_search = (op_r == OP_CHAR) && bd.ok && (run_inc >= k_eff) && (hits_r < mh);
    unique case (op_r)
      OP_CLEAR, OP_APPEND: stat.exec_result = 1'b1;
      OP_CHAR:             stat.exec_result = last_r;
      default:             stat.exec_result = 1'b0;
    endcase
    stat.range_open  = lo_r < hi_r;
    stat.key_eq      = rd_data == rolling_r;
    stat.want_result = last_r;
    stat.out_free    = !out_valid_r || out_ready;
  end

  // Config writes
  always_comb begin
    kmer_length_nxt = kmer_length_r;
    hit_goal_nxt    = hit_goal_r;
    if (cfg_we) begin
      if (cfg_idx == CFG_KMER_LENGTH) kmer_length_nxt = cfg_wdata[K_W-1:0];
      if (cfg_idx == CFG_HIT_GOAL)    hit_goal_nxt    = cfg_wdata[HITS_W-1:0];
    end
  end

  // Table, window, search and output updates
  always_comb begin
    seed_count_nxt = seed_count_r;
    last_seed_nxt  = last_seed_r;
    rolling_nxt    = rolling_r;
    run_nxt        = run_r;
    hits_nxt       = hits_r;
    res_status_nxt = res_status_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    out_valid_nxt  = out_valid_r;
    out_kind_nxt   = out_kind_r;
    out_status_nxt = out_status_r;
    out_hits_nxt   = out_hits_r;
    out_passed_nxt = out_passed_r;

    if (out_ready) out_valid_nxt = 1'b0;

    if (cmd.exec) begin
      unique case (op_r)
        OP_CLEAR: begin
          seed_count_nxt = '0;
          res_status_nxt = ST_OK;
        end
        OP_APPEND: begin
          res_status_nxt = app_status;
          if (app_status == ST_OK) begin
            seed_count_nxt = seed_count_r + 1'b1;
            last_seed_nxt  = seed_r;
          end
        end
        OP_CHAR: begin
          if (bd.ok) begin
            rolling_nxt = roll_shift;
            run_nxt     = run_inc;
          end else begin
            rolling_nxt = '0;
            run_nxt     = '0;
          end
          lo_nxt = '0;
          hi_nxt = seed_count_r;
        end
        default: ;
      endcase
    end

    // One binary search step on the registered read data
    if (cmd.narrow) begin
      priority if (rd_data == rolling_r) begin
        hits_nxt = hits_r + 1'b1;
      end else if (rd_data < rolling_r) begin
        lo_nxt = mid + 1'b1;
      end else begin
        hi_nxt = mid;
      end
    end

    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      if (op_r == OP_CHAR) begin
        out_kind_nxt   = KIND_VERDICT;
        out_status_nxt = ST_OK;
        out_hits_nxt   = verdict_hits;
        out_passed_nxt = verdict_hits >= mh;
        rolling_nxt    = '0;
        run_nxt        = '0;
        hits_nxt       = '0;
      end else begin
        out_kind_nxt   = KIND_TABLE;
        out_status_nxt = res_status_r;
        out_hits_nxt   = '0;
        out_passed_nxt = 1'b0;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kmer_length_r <= KMER_RESET;
      hit_goal_r    <= HIT_GOAL_RESET;
      seed_count_r  <= '0;
      rolling_r     <= '0;
      run_r         <= '0;
      hits_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      kmer_length_r <= kmer_length_nxt;
      hit_goal_r    <= hit_goal_nxt;
      seed_count_r  <= seed_count_nxt;
      rolling_r     <= rolling_nxt;
      run_r         <= run_nxt;
      hits_r        <= hits_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_op;
      seed_r <= in_seed;
      char_r <= in_char;
      last_r <= in_last;
    end
    last_seed_r  <= last_seed_nxt;
    res_status_r <= res_status_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    out_kind_r   <= out_kind_nxt;
    out_status_r <= out_status_nxt;
    out_hits_r   <= out_hits_nxt;
    out_passed_r <= out_passed_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_kind   = out_kind_r;
  assign out_status = out_status_r;
  assign out_hits   = out_hits_r;
  assign out_passed = out_passed_r;

endmodule

`default_nettype wire

// ----- rtl/kmer_seed_prefilter.sv -----
// Each word is captured in S_IDLE and applied in S_EXEC; no new word is taken before
// the last is done. A result waits in S_FINISH while the output word is held. A character
// that completes a window first runs binary-search probes (seed memory read in S_SEARCH,
// then compare in S_CHECK), at most 19, plus a final S_SEARCH on a miss.
// Reset (rst_n low, synchronous): empty table, cleared run, k = 16, hit threshold 1;
// the seed memory is not swept, so words are taken right after reset.
`default_nettype none

module kmer_seed_prefilter (
  input  wire                                 clk,
  input  wire                                 rst_n,
  // input words
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  input  wire  [ksp_pkg::IN_DATA_W-1:0]       in_tdata,  // [63:0] seed_code, [71:64] base_char
  input  wire  [ksp_pkg::OP_W-1:0]            in_tuser,  // [1:0] opcode
  input  wire                                 in_tlast,  // last_of_read
  // result words
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  output logic [ksp_pkg::OUT_DATA_W-1:0]      out_tdata, // [1:0] status, [9:2] hit_count,
                                                         // [10] passed, rest zero
  output logic                                out_tuser, // result_kind
  // configuration writes
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire  [ksp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [ksp_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import ksp_pkg::*;

  ksp_cmd_t            cmd;
  ksp_stat_t           stat;
  logic [STATUS_W-1:0] status;
  logic [HITS_W-1:0]   hit_count;
  logic                passed;

  assign cfg_ready = 1'b1;

  ksp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ksp_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_op      (in_tuser),
    .in_seed    (in_tdata[SEED_W-1:0]),
    .in_char    (in_tdata[SEED_W +: CHAR_W]),
    .in_last    (in_tlast),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_idx    (cfg_index),
    .cfg_wdata  (cfg_data),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_kind   (out_tuser),
    .out_status (status),
    .out_hits   (hit_count),
    .out_passed (passed)
  );

  // Pack result fields from the low bit up
  assign out_tdata = {{(OUT_DATA_W - STATUS_W - HITS_W - 1){1'b0}}, passed, hit_count, status};

endmodule

`default_nettype wire

// ----- rtl/ksp_checker.sv -----
// Port-level checks for kmer_seed_prefilter, attached by the bind below.
// Depends on ksp_pkg for port widths and codes.
`default_nettype none

module ksp_checker (
  input wire                            clk,
  input wire                            rst_n,
  input wire                            in_tvalid,
  input wire                            in_tready,
  input wire                            out_tvalid,
  input wire                            out_tready,
  input wire [ksp_pkg::OUT_DATA_W-1:0]  out_tdata,
  input wire                            out_tuser
);
  import ksp_pkg::*;

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // One word at a time: no acceptance right after an acceptance
  a_in_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while previous word in flight");

  // Table status words carry no count or pass flag
  a_table_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_TABLE |-> out_tdata[OUT_DATA_W-1:STATUS_W] == '0)
    else $error("table status word with verdict fields set");

  // A verdict has status zero, and a pass implies a nonzero count
  a_verdict_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_VERDICT |->
      out_tdata[STATUS_W-1:0] == ST_OK &&
      (!out_tdata[STATUS_W+HITS_W] || out_tdata[STATUS_W +: HITS_W] != '0))
    else $error("malformed verdict word");

  // Reset empties the output register
  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result word valid after reset");

endmodule

bind kmer_seed_prefilter ksp_checker u_ksp_checker (.*);

`default_nettype wire

// ----- test/kmer_seed_prefilter_test.sv -----
// Self-checking bench for kmer_seed_prefilter: seed table loads, read streams, verdicts.
// Needs only ksp_pkg and the block; a built-in predictor tracks table, window and hits.
`timescale 1ns / 100ps

module kmer_seed_prefilter_test;
  import ksp_pkg::*;

  localparam logic [OP_W-1:0]      OP_UNUSED     = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI  = 8'hFF;
  localparam int unsigned          RUN_LIMIT     = 4_000_000;
  localparam int unsigned          HOLD_OFF      = 400;
  localparam int unsigned          SETTLE_CYCLES = 100;
  localparam int unsigned          BACKLOG       = 512;
  localparam int unsigned          REPORT_CAP    = 100;
  localparam int unsigned          FILL_SEEDS    = 150;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [SEED_W-1:0] seed;
    logic [CHAR_W-1:0] ch;
    logic              last;
  } in_word_t;

  typedef struct packed {
    logic                kind;
    logic [STATUS_W-1:0] status;
    logic [HITS_W-1:0]   hits;
    logic                passed;
  } out_word_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [OP_W-1:0]       in_tuser = '0;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  kmer_seed_prefilter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [63:0] seed_code, [71:64] base_char
    .in_tuser   (in_tuser),   // [1:0] opcode
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [1:0] status, [9:2] hit_count, [10] passed
    .out_tuser  (out_tuser),  // result_kind
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Words waiting to be sent, results still owed by the block
  in_word_t    pend_words[$];
  out_word_t   due_results[$];
  bit          word_taken;
  int unsigned cyc, errors, stall_req, stall_seen, hold_left;

  // Predictor state
  logic [SEED_W-1:0] seed_mirror[$];
  logic [SEED_W-1:0] roll_code = '0;
  logic [K_W-1:0]    run_len = '0;
  logic [HITS_W-1:0] win_hits = '0;
  logic [K_W-1:0]    k_reg = KMER_RESET;
  logic [HITS_W-1:0] hits_reg = HIT_GOAL_RESET;

  // Stimulus generator state
  logic [SEED_W-1:0] phase_seeds[$];
  logic [CHAR_W-1:0] read_chars[$];
  int unsigned       gen_k = 16;
  logic [7:0]        k_plan [8] = '{8'd12, 8'd32, 8'h00, 8'hFF, 8'hD4, 8'h0B, 8'h21, 8'h4E};
  logic [7:0]        mh_plan [8] = '{8'd2, 8'd1, 8'd3, 8'd0, 8'hAA, 8'd1, 8'd255, 8'h55};
  bit                zero_plan [8] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};

  function automatic logic [SEED_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic int unsigned k_eff(input logic [K_W-1:0] v);
    if (v < 12) return 12;
    if (v > 32) return 32;
    return 32'(v);
  endfunction

  function automatic logic [SEED_W-1:0] win_mask(input int unsigned k);
    if (k >= 32) return '1;
    return (64'd1 << (2 * k)) - 64'd1;
  endfunction

  // Table is strictly ascending, so a binary search is exact membership
  function automatic bit seed_known(input logic [SEED_W-1:0] key);
    int unsigned lo, hi, mid;
    lo = 0;
    hi = seed_mirror.size();
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (seed_mirror[mid] == key) return 1'b1;
      if (seed_mirror[mid] < key) lo = mid + 1;
      else hi = mid;
    end
    return 1'b0;
  endfunction

  // Apply one accepted word to the predictor; returns 1 when a result is owed
  function automatic bit absorb_word(input in_word_t w, output out_word_t r);
    int unsigned k, need;
    logic        ok;
    logic [1:0]  b;
    r = '0;
    k = k_eff(k_reg);
    need = (hits_reg == 0) ? 1 : 32'(hits_reg);
    ok = 1'b1;
    b = 2'd0;
    case (w.op)
      OP_CLEAR: begin
        seed_mirror.delete();
        r.kind = KIND_TABLE;
        r.status = ST_OK;
        return 1'b1;
      end
      OP_APPEND: begin
        r.kind = KIND_TABLE;
        if (seed_mirror.size() != 0 && w.seed == seed_mirror[$]) r.status = ST_DUP;
        else if (seed_mirror.size() != 0 && w.seed < seed_mirror[$]) r.status = ST_ORDER;
        else if (seed_mirror.size() >= SEED_CAPACITY) r.status = ST_FULL;
        else begin
          seed_mirror.insert(seed_mirror.size(), w.seed);
          r.status = ST_OK;
        end
        return 1'b1;
      end
      OP_CHAR: begin
        case (w.ch)
          "A", "a": b = 2'd0;
          "C", "c": b = 2'd1;
          "G", "g": b = 2'd2;
          "T", "t": b = 2'd3;
          default:  ok = 1'b0;
        endcase
        if (!ok) begin
          run_len = '0;
          roll_code = '0;
        end else begin
          roll_code = {roll_code[SEED_W-3:0], b} & win_mask(k);
          if (run_len != RUN_MAX) run_len = run_len + 1'b1;
          if (run_len >= k && win_hits < need && seed_known(roll_code))
            win_hits = win_hits + 1'b1;
        end
        if (!w.last) return 1'b0;
        r.kind = KIND_VERDICT;
        r.hits = (win_hits < need) ? win_hits : HITS_W'(need);
        r.passed = (win_hits >= need);
        run_len = '0;
        roll_code = '0;
        win_hits = '0;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // ~7% idle per side, none during a quiet stretch that recurs through the run
  function automatic bit take_break();
    return ((cyc % 8000) < 6500) && ($urandom_range(0, 99) < 7);
  endfunction

  task automatic note_mismatch(input string field, input logic [63:0] want,
                               input logic [63:0] got);
    errors++;
    if (errors <= REPORT_CAP)
      $error("%s mismatch: expected %0h, got %0h", field, want, got);
  endtask

  // Clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Cycle count and run limit
  always @(posedge clk) begin
    cyc++;
    if (cyc >= RUN_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Sender: hold a word until taken, then offer the next one
  always @(negedge clk) begin : drive
    in_word_t w;
    if (rst_n && (!in_tvalid || word_taken)) begin
      word_taken = 1'b0;
      if (pend_words.size() != 0 && !take_break()) begin
        w = pend_words.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {w.ch, w.seed};
        in_tuser  <= w.op;
        in_tlast  <= w.last;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus a long hold-off on request
  always @(negedge clk) begin : sink
    if (rst_n) begin
      if (stall_req != stall_seen) begin
        stall_seen = stall_req;
        hold_left = HOLD_OFF;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= !take_break();
      end
    end
  end

  // Monitor: check result words, track register writes, predict accepted words
  always @(posedge clk) begin : watch
    in_word_t  w;
    out_word_t got, want, owed;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.kind   = out_tuser;
        got.status = out_tdata[1:0];
        got.hits   = out_tdata[9:2];
        got.passed = out_tdata[10];
        if (due_results.size() == 0) begin
          errors++;
          if (errors <= REPORT_CAP)
            $error("result word with none expected: kind %0d data %0h", out_tuser, out_tdata);
        end else begin
          want = due_results.pop_front();
          if (got.kind !== want.kind) note_mismatch("result_kind", want.kind, got.kind);
          if (got.status !== want.status) note_mismatch("status", want.status, got.status);
          if (got.hits !== want.hits) note_mismatch("hit_count", want.hits, got.hits);
          if (got.passed !== want.passed) note_mismatch("passed", want.passed, got.passed);
          if (out_tdata[OUT_DATA_W-1:11] !== '0)
            note_mismatch("padding", 0, out_tdata[OUT_DATA_W-1:11]);
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_KMER_LENGTH) k_reg = cfg_data[K_W-1:0];
        else if (cfg_index == CFG_HIT_GOAL) hits_reg = cfg_data;
      end
      if (in_tvalid && in_tready) begin
        w.op   = in_tuser;
        w.seed = in_tdata[SEED_W-1:0];
        w.ch   = in_tdata[IN_DATA_W-1:SEED_W];
        w.last = in_tlast;
        if (absorb_word(w, owed)) due_results.insert(due_results.size(), owed);
        word_taken = 1'b1;
      end
    end
  end

  task automatic push_word(input logic [OP_W-1:0] op, input logic [SEED_W-1:0] seed,
                           input logic [CHAR_W-1:0] ch, input logic last);
    in_word_t w;
    while (pend_words.size() >= BACKLOG) @(negedge clk);
    w = '{op: op, seed: seed, ch: ch, last: last};
    pend_words.insert(pend_words.size(), w);
  endtask

  // Don't-care fields are randomized so every bit toggles
  task automatic push_seed(input logic [SEED_W-1:0] s);
    push_word(OP_APPEND, s, CHAR_W'($urandom), 1'($urandom_range(0, 1)));
  endtask

  task automatic push_clear();
    push_word(OP_CLEAR, rand64(), CHAR_W'($urandom), 1'($urandom_range(0, 1)));
  endtask

  task automatic push_stray();
    push_word(OP_UNUSED, rand64(), CHAR_W'($urandom), 1'($urandom_range(0, 1)));
  endtask

  function automatic logic [CHAR_W-1:0] base_char(input logic [1:0] b);
    logic [CHAR_W-1:0] c;
    case (b)
      2'd0:    c = "A";
      2'd1:    c = "C";
      2'd2:    c = "G";
      default: c = "T";
    endcase
    return $urandom_range(0, 1) ? (c | 8'h20) : c;
  endfunction

  // Seed as k characters, first base from the top bits
  task automatic spell(input logic [SEED_W-1:0] s, input int unsigned k);
    for (int unsigned i = k; i > 0; i--)
      read_chars.insert(read_chars.size(), base_char(s[2*(i-1) +: 2]));
  endtask

  // Character words of read_chars; stray and append words sprinkled in between
  task automatic send_chars(input bit close);
    foreach (read_chars[i]) begin
      if ($urandom_range(0, 99) < 3) begin
        if ($urandom_range(0, 1)) push_stray();
        else push_seed(rand64());
      end
      push_word(OP_CHAR, rand64(), read_chars[i], close && (i == read_chars.size() - 1));
    end
  endtask

  // Read built from table seeds, random bases and junk characters
  task automatic push_read(input bit close);
    int unsigned r;
    read_chars.delete();
    repeat ($urandom_range(1, 3)) begin
      r = $urandom_range(0, 99);
      if (r < 55 && phase_seeds.size() != 0)
        spell(phase_seeds[$urandom_range(0, phase_seeds.size() - 1)], gen_k);
      else if (r < 88)
        repeat ($urandom_range(1, 8))
          read_chars.insert(read_chars.size(), base_char(2'($urandom_range(0, 3))));
      else
        read_chars.insert(read_chars.size(), CHAR_W'($urandom_range(0, 255)));
    end
    send_chars(close);
  endtask

  // Ascending k-base seeds with duplicate and out-of-order appends mixed in
  task automatic load_table(input int unsigned n, input bit from_zero);
    logic [SEED_W-1:0] m, span, cur;
    int unsigned       r;
    m = win_mask(gen_k);
    span = m / (n + 1);
    if (span == 0) span = 1;
    cur = from_zero ? '0 : rand64() % span;
    phase_seeds.delete();
    repeat (n) begin
      phase_seeds.insert(phase_seeds.size(), cur);
      push_seed(cur);
      r = $urandom_range(0, 99);
      if (r < 10) push_seed(cur);
      else if (r < 15 && cur != 0) push_seed(rand64() % cur);
      cur = cur + 1 + rand64() % span;
    end
    // all-T seed at the top of the range
    if (from_zero) begin
      phase_seeds.insert(phase_seeds.size(), m);
      push_seed(m);
    end
    // a seed wider than k is stored but never matches
    if (gen_k < 32 && $urandom_range(0, 2) == 0) push_seed(m + 1 + (rand64() >> 1));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Sender pauses until all owed results are back, then lets the block go quiet
  task automatic settle();
    while (pend_words.size() != 0 || in_tvalid || due_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    logic [SEED_W-1:0] s;
    repeat (12) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed: append ordering on small and empty tables, ignored words, one hit
    s = 64'h0000_0000_1B1B_E4E4;
    push_seed('0);
    push_seed('0);
    push_seed(s);
    push_seed(s - 1);
    push_word(OP_UNUSED, '1, 8'hFF, 1'b1);
    push_word(OP_CLEAR, '1, 8'h41, 1'b1);
    push_seed(s);
    push_seed('1);
    push_seed('1);
    push_seed('0);
    read_chars.delete();
    spell(s, 16);
    send_chars(1'b1);
    read_chars = '{8'h4E};
    send_chars(1'b1);

    // Random phases, one register setting each; every phase leaves a read open
    for (int unsigned j = 0; j < 8; j++) begin
      settle();
      write_reg(CFG_KMER_LENGTH, k_plan[j]);
      write_reg(CFG_HIT_GOAL, mh_plan[j]);
      if (j == 3) begin
        write_reg(CFG_SPARE_LO, CFG_DATA_W'($urandom));
        write_reg(CFG_SPARE_HI, CFG_DATA_W'($urandom));
      end
      @(negedge clk) cfg_valid <= 1'b0;
      gen_k = k_eff(k_plan[j][K_W-1:0]);
      if (j == 0 || zero_plan[j] || $urandom_range(0, 99) < 85) push_clear();
      load_table($urandom_range(1, 20), zero_plan[j]);
      // long all-A read saturates the count at the largest threshold
      if (mh_plan[j] == 8'd255) begin
        read_chars.delete();
        repeat (300) read_chars.insert(read_chars.size(), base_char(2'd0));
        send_chars(1'b1);
      end
      repeat ($urandom_range(1, 3)) push_read(1'b1);
      push_read(1'b0);
    end

    // Deep backlog: long receiver hold-off while the sender keeps appending
    settle();
    write_reg(CFG_KMER_LENGTH, 8'd32);
    write_reg(CFG_HIT_GOAL, 8'd4);
    @(negedge clk) cfg_valid <= 1'b0;
    gen_k = 32;
    stall_req++;
    push_clear();
    phase_seeds.delete();
    for (int unsigned i = 0; i < FILL_SEEDS; i++) begin
      s = (64'(i) << (SEED_W - 8)) | (rand64() >> 9);
      push_seed(s);
      if (i % 16 == 0 || i == FILL_SEEDS - 1) phase_seeds.insert(phase_seeds.size(), s);
    end
    // duplicate and ordering checks on a loaded table
    push_seed(s);
    push_seed(s - 1);
    push_seed(s + 1);
    push_seed('1);
    repeat (4) push_read(1'b1);
    push_clear();
    push_seed(rand64());
    push_read(1'b1);

    settle();
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- kmer_seed_prefilter.f -----
rtl/ksp_pkg.sv
rtl/ksp_ram.sv
rtl/ksp_ctrl.sv
rtl/ksp_dp.sv
rtl/kmer_seed_prefilter.sv
rtl/ksp_checker.sv
test/kmer_seed_prefilter_test.sv
